>>> rtl/rkf_pkg.sv
`default_nettype none

package rkf_pkg;

   // Geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = 11;
   localparam int HGT_W     = 16;
   localparam int HELD_W    = $clog2(MAX_WIDTH + 2);
   localparam int XW        = (WID_W > COL_W + 1) ? WID_W : COL_W + 1;
   localparam int SXW       = XW + 2;
   localparam int MIN_DIM   = 3;

   // Pixel packing
   localparam int PIX_W     = 32;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int ALPHA_LSB = 24;
   localparam int WIN_SIZE  = 9;

   // Filter arithmetic
   localparam int SUM_W       = 13;
   localparam int NSUM_W      = 10;
   localparam int RECIP_SHIFT = 17;
   localparam logic [SUM_W-1:0] RECIP_NINE = 13'd7282;

   // Output queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_LEFT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_TOP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_RIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_BOTTOM   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_OUT    = 3'd7;

   // Register reset values
   localparam logic [1:0]       KERNEL_MODE_RST  = 2'd0;
   localparam logic [WID_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
   localparam logic [HGT_W-1:0] IMAGE_HEIGHT_RST = 16'd3;
   localparam logic [WID_W-1:0] SEL_LEFT_RST     = 11'd0;
   localparam logic [HGT_W-1:0] SEL_TOP_RST      = 16'd0;
   localparam logic [WID_W-1:0] SEL_RIGHT_RST    = 11'd1024;
   localparam logic [HGT_W-1:0] SEL_BOTTOM_RST   = 16'd3;
   localparam logic [7:0]       ALPHA_OUT_RST    = 8'd255;

   // Kernel modes
   localparam logic [1:0] MODE_EDGE    = 2'd0;
   localparam logic [1:0] MODE_SHARPEN = 2'd1;
   localparam logic [1:0] MODE_BOX     = 2'd2;
   localparam logic [1:0] MODE_GAUSS   = 2'd3;

   // Request operations
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/rkf_ram.sv
`default_nettype none

module rkf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write, one registered read; a read of the entry being written sees old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/rgb_kernel_filter_3x3.sv
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_item  (operation, pixel_in)
// rsp      out        rsp_valid/rsp_stall   rsp_item  (pixel_out, frame_end)
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One request per clock, push or drain, while req_stall is low; the row memory
// takes one read and one write every cycle, which sets that rate. A request
// passes in order through row memory read, window, weighted sum and rounding.
// Synchronous reset clears config, flags and counters, not the row memory.
// req_stall rises only when the 8-entry output queue plus results still in the
// three pipeline stages could fill it; rsp_stall never stalls the pipeline.

module rgb_kernel_filter_3x3 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rkf_pkg::req_type                 req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rkf_pkg::rsp_type                 rsp_item,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rkf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rkf_pkg::CSR_DATA_W-1:0]   csr_data
);

   import rkf_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]       kernel_mode_ff;
   logic [WID_W-1:0] image_width_ff;
   logic [HGT_W-1:0] image_height_ff;
   logic [WID_W-1:0] sel_left_ff;
   logic [HGT_W-1:0] sel_top_ff;
   logic [WID_W-1:0] sel_right_ff;
   logic [HGT_W-1:0] sel_bottom_ff;
   logic [7:0]       alpha_out_ff;
   logic             csr_wr;
   logic             geo_restart;

   assign csr_ready   = 1'b1;
   assign csr_wr      = csr_valid && csr_ready;
   assign geo_restart = csr_wr &&
                        (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff  <= KERNEL_MODE_RST;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         sel_left_ff     <= SEL_LEFT_RST;
         sel_top_ff      <= SEL_TOP_RST;
         sel_right_ff    <= SEL_RIGHT_RST;
         sel_bottom_ff   <= SEL_BOTTOM_RST;
         alpha_out_ff    <= ALPHA_OUT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_KERNEL_MODE:  kernel_mode_ff  <= csr_data[1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[WID_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[HGT_W-1:0];
            CSR_SEL_LEFT:     sel_left_ff     <= csr_data[WID_W-1:0];
            CSR_SEL_TOP:      sel_top_ff      <= csr_data[HGT_W-1:0];
            CSR_SEL_RIGHT:    sel_right_ff    <= csr_data[WID_W-1:0];
            CSR_SEL_BOTTOM:   sel_bottom_ff   <= csr_data[HGT_W-1:0];
            CSR_ALPHA_OUT:    alpha_out_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // effective frame size: width saturated to 3..MAX_WIDTH, height at least 3
   logic [XW-1:0]    w_eff;
   logic [HGT_W-1:0] h_eff;

   always_comb begin
      if (XW'(image_width_ff) < XW'(MIN_DIM)) begin
         w_eff = XW'(MIN_DIM);
      end else if (XW'(image_width_ff) > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(image_width_ff);
      end
      h_eff = (image_height_ff < HGT_W'(MIN_DIM)) ? HGT_W'(MIN_DIM) : image_height_ff;
   end

   // ---------------------------------------------------------------------
   // Request stage: position counters, hold count, row memory address
   // ---------------------------------------------------------------------
   logic [COL_W-1:0]  column_count_ff, column_count_in;
   logic [HGT_W-1:0]  row_count_ff, row_count_in;
   logic [HELD_W-1:0] held_ff, held_in;

   logic              accept;
   logic              is_push;
   logic [XW-1:0]     c_x;
   logic [XW-1:0]     held_x;
   logic              col_last;
   logic              row_last;
   logic              delay_full;
   logic              req_emit;
   logic [SXW-1:0]    dt0, dt1, dt2;
   logic [SXW-1:0]    c_plus_w;
   logic [COL_W-1:0]  drain_col;
   logic              drain_fe;
   logic              push_fe;
   logic [COL_W-1:0]  push_ocol;
   logic [HGT_W-1:0]  push_orow;
   logic [COL_W-1:0]  ram_rd_addr;

   assign accept = req_valid && !req_stall;
   assign is_push = (req_item.operation == OP_PUSH);
   assign c_x = XW'(column_count_ff);
   assign held_x = XW'(held_ff);
   assign col_last = (c_x + XW'(1)) == w_eff;
   assign row_last = row_count_ff == (h_eff - HGT_W'(1));
   assign delay_full = held_x > w_eff;

   always_comb begin
      // drain: oldest held pixel sits at column (c - held) mod w
      dt0 = SXW'(column_count_ff) - SXW'(held_ff);
      dt1 = dt0 + SXW'(w_eff);
      dt2 = dt1 + SXW'(w_eff);
      if (!dt0[SXW-1]) begin
         drain_col = dt0[COL_W-1:0];
      end else if (!dt1[SXW-1]) begin
         drain_col = dt1[COL_W-1:0];
      end else begin
         drain_col = dt2[COL_W-1:0];
      end

      // rows back from the current one: 0, 1 or 2; last row check per case
      c_plus_w = SXW'(column_count_ff) + SXW'(w_eff);
      if (held_x <= c_x) begin
         drain_fe = row_last;
      end else if (SXW'(held_ff) <= c_plus_w) begin
         drain_fe = row_count_ff == HGT_W'(0);
      end else begin
         drain_fe = row_count_ff == HGT_W'(1);
      end
      drain_fe = drain_fe && (drain_col == COL_W'(w_eff - XW'(1)));

      // push: output pixel is one row plus one pixel behind
      if (column_count_ff != COL_W'(0)) begin
         push_ocol = column_count_ff - COL_W'(1);
         push_orow = (row_count_ff == HGT_W'(0)) ? h_eff - HGT_W'(1)
                                                 : row_count_ff - HGT_W'(1);
      end else begin
         push_ocol = COL_W'(w_eff - XW'(1));
         push_orow = (row_count_ff >= HGT_W'(2)) ? row_count_ff - HGT_W'(2)
                                                 : row_count_ff + h_eff - HGT_W'(2);
      end
      push_fe = (column_count_ff == COL_W'(0)) && (row_count_ff == HGT_W'(1));

      req_emit    = is_push ? delay_full : (held_ff != HELD_W'(0));
      ram_rd_addr = is_push ? column_count_ff : drain_col;
   end

   // counter next state
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      held_in         = held_ff;
      if (geo_restart) begin
         column_count_in = '0;
         row_count_in    = '0;
         held_in         = '0;
      end else if (accept) begin
         if (is_push) begin
            if (col_last) begin
               column_count_in = '0;
               row_count_in    = row_last ? HGT_W'(0) : row_count_ff + HGT_W'(1);
            end else begin
               column_count_in = column_count_ff + COL_W'(1);
            end
            if (!delay_full) begin
               held_in = held_ff + HELD_W'(1);
            end
         end else if (held_ff != HELD_W'(0)) begin
            held_in = held_ff - HELD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         held_ff         <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         held_ff         <= held_in;
      end
   end

   // ---------------------------------------------------------------------
   // Row memory: entry = {upper row pixel, lower row pixel} per column
   // ---------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic                 s1_op_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   logic [COL_W-1:0]     s1_addr_ff;
   logic                 s1_emit_ff;
   logic                 s1_upper_ff;
   logic                 s1_fe_ff;
   logic [COL_W-1:0]     s1_ocol_ff;
   logic [HGT_W-1:0]     s1_orow_ff;

   logic                 ram_wr_en;
   logic [2*PIX_W-1:0]   ram_wr_data;
   logic [2*PIX_W-1:0]   ram_rd_data;
   logic [2*PIX_W-1:0]   row_data;
   logic                 fwd_hit_ff;
   logic [2*PIX_W-1:0]   fwd_data_ff;

   rkf_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // forward a write that lands in the same cycle as the read of that column
   assign row_data    = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign ram_wr_en   = s1_valid_ff && (s1_op_ff == OP_PUSH);
   assign ram_wr_data = {row_data[PIX_W-1:0], s1_pix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= accept && ram_wr_en && (s1_addr_ff == ram_rd_addr);
      end
      fwd_data_ff <= ram_wr_data;
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && req_emit;
      end
      s1_op_ff    <= req_item.operation;
      s1_pix_ff   <= req_item.pixel_in;
      s1_addr_ff  <= ram_rd_addr;
      s1_upper_ff <= delay_full;
      s1_fe_ff    <= is_push ? push_fe : drain_fe;
      s1_ocol_ff  <= push_ocol;
      s1_orow_ff  <= push_orow;
   end

   // ---------------------------------------------------------------------
   // Stage 1: window shift and selection check
   // ---------------------------------------------------------------------
   logic [PIX_W-1:0] window_ff [WIN_SIZE];
   logic [PIX_W-1:0] window_in [WIN_SIZE];
   logic [WID_W-1:0] sel_l;
   logic [HGT_W-1:0] sel_t;
   logic [XW-1:0]    sel_r;
   logic [HGT_W-1:0] sel_b;
   logic             in_sel;

   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         window_in[i] = window_ff[i];
      end
      if (ram_wr_en) begin
         for (int k = 0; k < 3; k++) begin
            window_in[3*k]   = window_ff[3*k+1];
            window_in[3*k+1] = window_ff[3*k+2];
         end
         window_in[2] = row_data[2*PIX_W-1:PIX_W];
         window_in[5] = row_data[PIX_W-1:0];
         window_in[8] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         window_ff[i] <= window_in[i];
      end
   end

   // selection edges on the image border move one pixel inward
   always_comb begin
      sel_l = (sel_left_ff == WID_W'(0)) ? WID_W'(1) : sel_left_ff;
      sel_t = (sel_top_ff == HGT_W'(0)) ? HGT_W'(1) : sel_top_ff;
      sel_r = (XW'(sel_right_ff) >= w_eff) ? w_eff - XW'(1) : XW'(sel_right_ff);
      sel_b = (sel_bottom_ff >= h_eff) ? h_eff - HGT_W'(1) : sel_bottom_ff;
      in_sel = (XW'(s1_ocol_ff) >= XW'(sel_l)) && (XW'(s1_ocol_ff) < sel_r) &&
               (s1_orow_ff >= sel_t) && (s1_orow_ff < sel_b);
   end

   // stage 2 registers
   logic             s2_emit_ff;
   logic             s2_op_ff;
   logic             s2_sel_ff;
   logic             s2_fe_ff;
   logic [PIX_W-1:0] s2_drain_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
      s2_op_ff        <= s1_op_ff;
      s2_sel_ff       <= (s1_op_ff == OP_PUSH) && in_sel;
      s2_fe_ff        <= s1_fe_ff;
      s2_drain_pix_ff <= s1_upper_ff ? row_data[2*PIX_W-1:PIX_W] : row_data[PIX_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Stage 2: masked channel bytes and kernel weighted sums
   // ---------------------------------------------------------------------
   function automatic logic signed [SUM_W-1:0] kernel_sum(
      input logic [1:0]        mode,
      input logic [CHAN_W-1:0] ctr,
      input logic [NSUM_W-1:0] nbr,
      input logic [NSUM_W-1:0] cor
   );
      logic signed [SUM_W-1:0] vc;
      logic signed [SUM_W-1:0] vn;
      logic signed [SUM_W-1:0] vk;
      logic signed [SUM_W-1:0] s;
      vc = SUM_W'(ctr);
      vn = SUM_W'(nbr);
      vk = SUM_W'(cor);
      case (mode)
         MODE_EDGE:    s = (vc <<< 3) - vn - vk;
         MODE_SHARPEN: s = (vc <<< 2) + vc - vn;
         MODE_BOX:     s = vc + vn + vk;
         MODE_GAUSS:   s = (vc <<< 2) + (vn <<< 1) + vk;
         default:      s = '0;
      endcase
      return s;
   endfunction

   logic [CHAN_W-1:0]       mbyte [NUM_CHAN][WIN_SIZE];
   logic [NSUM_W-1:0]       nbr_sum [NUM_CHAN];
   logic [NSUM_W-1:0]       cor_sum [NUM_CHAN];
   logic signed [SUM_W-1:0] s2_sum [NUM_CHAN];
   logic [PIX_W-1:0]        s2_pass_pix;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         // each channel byte is gated by the pixel's top byte
         for (int i = 0; i < WIN_SIZE; i++) begin
            mbyte[ch][i] = window_ff[i][CHAN_W*ch +: CHAN_W] &
                           window_ff[i][ALPHA_LSB +: CHAN_W];
         end
         nbr_sum[ch] = NSUM_W'(mbyte[ch][1]) + NSUM_W'(mbyte[ch][3]) +
                       NSUM_W'(mbyte[ch][5]) + NSUM_W'(mbyte[ch][7]);
         cor_sum[ch] = NSUM_W'(mbyte[ch][0]) + NSUM_W'(mbyte[ch][2]) +
                       NSUM_W'(mbyte[ch][6]) + NSUM_W'(mbyte[ch][8]);
         s2_sum[ch]  = kernel_sum(kernel_mode_ff, mbyte[ch][4], nbr_sum[ch], cor_sum[ch]);
      end
      s2_pass_pix = (s2_op_ff == OP_PUSH) ? window_ff[4] : s2_drain_pix_ff;
   end

   // stage 3 registers
   logic                    s3_emit_ff;
   logic                    s3_sel_ff;
   logic                    s3_fe_ff;
   logic [PIX_W-1:0]        s3_pass_ff;
   logic signed [SUM_W-1:0] s3_sum_ff [NUM_CHAN];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_emit_ff <= 1'b0;
      end else begin
         s3_emit_ff <= s2_emit_ff;
      end
      s3_sel_ff  <= s2_sel_ff;
      s3_fe_ff   <= s2_fe_ff;
      s3_pass_ff <= s2_pass_pix;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         s3_sum_ff[ch] <= s2_sum[ch];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: scale, round half up, clamp, pack
   // ---------------------------------------------------------------------
   function automatic logic [CHAN_W-1:0] scale_channel(
      input logic [1:0]              mode,
      input logic signed [SUM_W-1:0] s
   );
      logic [SUM_W-1:0]   x;
      logic [2*SUM_W-1:0] prod;
      logic [SUM_W-1:0]   g;
      logic [CHAN_W-1:0]  res;
      // box: (2s+9)/18 through a reciprocal; sums are never negative there
      x    = {s[SUM_W-2:0], 1'b0} + SUM_W'(9);
      prod = (2*SUM_W)'(x) * (2*SUM_W)'(RECIP_NINE);
      g    = SUM_W'(s) + SUM_W'(8);
      case (mode)
         MODE_BOX:   res = prod[RECIP_SHIFT +: CHAN_W];
         MODE_GAUSS: res = g[4 +: CHAN_W];
         default: begin
            if (s < 0) begin
               res = '0;
            end else if (s > SUM_W'(255)) begin
               res = '1;
            end else begin
               res = s[CHAN_W-1:0];
            end
         end
      endcase
      return res;
   endfunction

   logic [CHAN_W-1:0] chan_res [NUM_CHAN];
   rsp_type           result;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         chan_res[ch] = scale_channel(kernel_mode_ff, s3_sum_ff[ch]);
      end
      result.pixel_out = s3_sel_ff ? {alpha_out_ff, chan_res[2], chan_res[1], chan_res[0]}
                                   : s3_pass_ff;
      result.frame_end = s3_fe_ff;
   end

   // ---------------------------------------------------------------------
   // Output queue
   // ---------------------------------------------------------------------
   rsp_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic                  fifo_pop;
   logic [FIFO_CNT_W:0]   fill_sum;

   assign rsp_valid = fifo_cnt_ff != FIFO_CNT_W'(0);
   assign rsp_item  = fifo_ff[rd_ptr_ff];
   assign fifo_pop  = rsp_valid && !rsp_stall;

   // hold off requests while results in flight could overfill the queue
   assign fill_sum  = (FIFO_CNT_W+1)'(fifo_cnt_ff) + (FIFO_CNT_W+1)'(s1_emit_ff) +
                      (FIFO_CNT_W+1)'(s2_emit_ff) + (FIFO_CNT_W+1)'(s3_emit_ff);
   assign req_stall = fill_sum >= (FIFO_CNT_W+1)'(FIFO_DEPTH);

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      case ({s3_emit_ff, fifo_pop})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(1);
         2'b01:   fifo_cnt_in = fifo_cnt_ff - FIFO_CNT_W'(1);
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (s3_emit_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
      if (s3_emit_ff) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("output queue count out of range");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s3_emit_ff |-> (fifo_cnt_ff != FIFO_CNT_W'(FIFO_DEPTH)) || fifo_pop)
      else $error("result written into a full output queue");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_x <= w_eff + XW'(1))
      else $error("held pixel count exceeds one row plus one");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      c_x < w_eff)
      else $error("column counter beyond the row width");

   a_forward_source: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> $past(ram_wr_en))
      else $error("row memory forward without a write in the previous cycle");

endmodule

`default_nettype wire
